/* hdl/egl_pkg.sv */
// shared widths, reset value and saturating add for the elevation tracker
package egl_pkg;

   localparam int ALT_W = 16;
   localparam int MAX_W = 15;
   localparam int ACC_W = 32;

   localparam logic signed [ALT_W-1:0] LOWEST_RESET = 16'sh7FFF;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [ACC_W-1:0] amount);
      logic [ACC_W:0] sum;
      sum = {1'b0, acc} + {1'b0, amount};
      return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
   endfunction

endpackage

/* hdl/egl_if.sv */
// sample and statistics channel interfaces

interface egl_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [egl_pkg::ALT_W-1:0]       altitude;
   logic                                   start_of_route;

   modport source  (output valid, altitude, start_of_route, input ready);
   modport sink    (input valid, altitude, start_of_route, output ready);
   modport monitor (input valid, ready, altitude, start_of_route);
endinterface

interface egl_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [egl_pkg::ACC_W-1:0]              avg_gain_tenths;
   logic [egl_pkg::ACC_W-1:0]              avg_loss_tenths;
   logic [egl_pkg::ACC_W-1:0]              raw_gain_m;
   logic signed [egl_pkg::ALT_W-1:0]       min_altitude;
   logic [egl_pkg::MAX_W-1:0]              max_altitude;
   logic [egl_pkg::ACC_W-1:0]              sample_count;

   modport source  (output valid, avg_gain_tenths, avg_loss_tenths, raw_gain_m,
                    min_altitude, max_altitude, sample_count, input ready);
   modport sink    (input valid, avg_gain_tenths, avg_loss_tenths, raw_gain_m,
                    min_altitude, max_altitude, sample_count, output ready);
   modport monitor (input valid, ready, avg_gain_tenths, avg_loss_tenths, raw_gain_m,
                    min_altitude, max_altitude, sample_count);
endinterface

/* hdl/elevation_gain_loss_tracker.sv */
// elevation gain and loss tracker: windowed climb statistics over an altitude stream
//
// usage
//  - req_chan carries one altitude sample (whole metres, signed) per item, plus a
//    start_of_route flag that clears every statistic before that sample is used
//  - rsp_chan returns one item per sample: averaged gain and loss (units of
//    1/WINDOW_LEN metre), raw gain, minimum, maximum (floor of zero) and count
//  - the last WINDOW_LEN samples sit in a small synchronous ring memory; the
//    oldest entry is read at accept and subtracted from the running window sum
//  - path: a sample accepted into the update stage moves on into the statistics
//    registers, which drive rsp_chan, once the result register frees
//  - throughput: one item per cycle while results are taken; the update stage
//    (with the ring read at accept) and the statistics form a two-deep pipeline
//  - the statistics registers double as the output register, so a stalled
//    receiver holds the result stable; the update stage keeps one more item and
//    the input stalls only when both are full
//  - reset (synchronous) empties the pipeline and returns all statistics to their
//    start values: minimum 32767, everything else zero; ring contents are left
//    as they are, since the fill count keeps unwritten entries from being used
module elevation_gain_loss_tracker #(
   parameter int WINDOW_LEN = 10
) (
   input  logic      clock,
   input  logic      reset,
   egl_req_if.sink   req_chan,
   egl_rsp_if.source rsp_chan
);

   localparam int PTR_W   = $clog2(WINDOW_LEN);
   localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
   localparam int TOTAL_W = egl_pkg::ALT_W + $clog2(WINDOW_LEN);
   localparam int ALT_W   = egl_pkg::ALT_W;
   localparam int ACC_W   = egl_pkg::ACC_W;
   localparam int MAX_W   = egl_pkg::MAX_W;

   // ring memory of the last samples
   logic signed [ALT_W-1:0] ring_mem [WINDOW_LEN];
   logic signed [ALT_W-1:0] ring_rd_ff;

   // front end: ring pointer and fill count
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  rd_addr;
   logic [FILL_W-1:0] fill_base;
   logic              drop_old;
   logic              req_take;

   // update stage
   logic                    s1_vld_ff, s1_vld_in;
   logic signed [ALT_W-1:0] s1_alt_ff;
   logic                    s1_start_ff;
   logic [PTR_W-1:0]        s1_addr_ff;
   logic                    s1_drop_ff;
   logic                    s1_full_ff;
   logic                    advance;
   logic                    s1_go;

   // statistics, also the output register
   logic                      out_vld_ff, out_vld_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic signed [TOTAL_W-1:0] prev_total_ff, prev_total_in;
   logic                      prev_total_vld_ff, prev_total_vld_in;
   logic signed [ALT_W-1:0]   prev_sample_ff, prev_sample_in;
   logic                      prev_sample_vld_ff, prev_sample_vld_in;
   logic [ACC_W-1:0]          gain_avg_ff, gain_avg_in;
   logic [ACC_W-1:0]          loss_avg_ff, loss_avg_in;
   logic [ACC_W-1:0]          gain_raw_ff, gain_raw_in;
   logic signed [ALT_W-1:0]   lowest_ff, lowest_in;
   logic [MAX_W-1:0]          highest_ff, highest_in;
   logic [ACC_W-1:0]          count_ff, count_in;

   // handshake: result register frees when empty or taken
   assign advance        = !out_vld_ff || rsp_chan.ready;
   assign s1_go          = s1_vld_ff && advance;
   assign req_chan.ready = !s1_vld_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // front end: a start item restarts the ring at entry zero
   always_comb begin
      rd_addr   = req_chan.start_of_route ? '0 : ptr_ff;
      fill_base = req_chan.start_of_route ? '0 : fill_ff;
      drop_old  = (fill_base == FILL_W'(WINDOW_LEN));
      fill_in   = drop_old ? fill_base : fill_base + 1'b1;
      ptr_in    = (rd_addr == PTR_W'(WINDOW_LEN - 1)) ? '0 : rd_addr + 1'b1;
   end

   // oldest entry read at accept, new sample written from the update stage
   always_ff @(posedge clock) begin
      if (req_take) begin
         ring_rd_ff <= ring_mem[rd_addr];
      end
      if (s1_go) begin
         ring_mem[s1_addr_ff] <= s1_alt_ff;
      end
   end

   always_comb begin
      s1_vld_in = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         fill_ff   <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         if (req_take) begin
            ptr_ff  <= ptr_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_alt_ff   <= req_chan.altitude;
         s1_start_ff <= req_chan.start_of_route;
         s1_addr_ff  <= rd_addr;
         s1_drop_ff  <= drop_old;
         s1_full_ff  <= (fill_in == FILL_W'(WINDOW_LEN));
      end
   end

   // update stage: statistics after this sample
   always_comb begin
      logic signed [TOTAL_W-1:0] b_total;
      logic signed [TOTAL_W-1:0] b_prev_total;
      logic                      b_prev_total_vld;
      logic signed [ALT_W-1:0]   b_prev_sample;
      logic                      b_prev_sample_vld;
      logic [ACC_W-1:0]          b_gain_avg;
      logic [ACC_W-1:0]          b_loss_avg;
      logic [ACC_W-1:0]          b_gain_raw;
      logic signed [ALT_W-1:0]   b_lowest;
      logic [MAX_W-1:0]          b_highest;
      logic [ACC_W-1:0]          b_count;
      logic signed [TOTAL_W:0]   diff;
      logic [TOTAL_W:0]          diff_mag;
      logic signed [ALT_W:0]     rise;

      b_total           = s1_start_ff ? '0 : total_ff;
      b_prev_total      = s1_start_ff ? '0 : prev_total_ff;
      b_prev_total_vld  = s1_start_ff ? 1'b0 : prev_total_vld_ff;
      b_prev_sample     = s1_start_ff ? '0 : prev_sample_ff;
      b_prev_sample_vld = s1_start_ff ? 1'b0 : prev_sample_vld_ff;
      b_gain_avg        = s1_start_ff ? '0 : gain_avg_ff;
      b_loss_avg        = s1_start_ff ? '0 : loss_avg_ff;
      b_gain_raw        = s1_start_ff ? '0 : gain_raw_ff;
      b_lowest          = s1_start_ff ? egl_pkg::LOWEST_RESET : lowest_ff;
      b_highest         = s1_start_ff ? '0 : highest_ff;
      b_count           = s1_start_ff ? '0 : count_ff;

      // running window sum
      total_in = b_total + TOTAL_W'(s1_alt_ff)
                 - (s1_drop_ff ? TOTAL_W'(ring_rd_ff) : TOTAL_W'(0));

      // window sum movement, counted only between two full windows
      diff     = (TOTAL_W + 1)'(total_in) - (TOTAL_W + 1)'(b_prev_total);
      diff_mag = (diff < 0) ? unsigned'(-diff) : unsigned'(diff);
      gain_avg_in       = b_gain_avg;
      loss_avg_in       = b_loss_avg;
      prev_total_in     = b_prev_total;
      prev_total_vld_in = b_prev_total_vld;
      if (s1_full_ff) begin
         if (b_prev_total_vld && diff > 0) begin
            gain_avg_in = egl_pkg::sat_add(b_gain_avg,
                             {{(ACC_W - TOTAL_W - 1){1'b0}}, diff_mag});
         end else if (b_prev_total_vld && diff < 0) begin
            loss_avg_in = egl_pkg::sat_add(b_loss_avg,
                             {{(ACC_W - TOTAL_W - 1){1'b0}}, diff_mag});
         end
         prev_total_in     = total_in;
         prev_total_vld_in = 1'b1;
      end

      // raw climb between consecutive samples
      rise        = (ALT_W + 1)'(s1_alt_ff) - (ALT_W + 1)'(b_prev_sample);
      gain_raw_in = b_gain_raw;
      if (b_prev_sample_vld && rise > 0) begin
         gain_raw_in = egl_pkg::sat_add(b_gain_raw,
                          {{(ACC_W - ALT_W - 1){1'b0}}, unsigned'(rise)});
      end
      prev_sample_in     = s1_alt_ff;
      prev_sample_vld_in = 1'b1;

      // extremes, maximum never below zero
      highest_in = (s1_alt_ff > $signed({1'b0, b_highest})) ? s1_alt_ff[MAX_W-1:0]
                                                            : b_highest;
      lowest_in  = (s1_alt_ff < b_lowest) ? s1_alt_ff : b_lowest;
      count_in   = egl_pkg::sat_add(b_count, ACC_W'(1));
   end

   always_comb begin
      out_vld_in = s1_go ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff         <= 1'b0;
         total_ff           <= '0;
         prev_total_ff      <= '0;
         prev_total_vld_ff  <= 1'b0;
         prev_sample_ff     <= '0;
         prev_sample_vld_ff <= 1'b0;
         gain_avg_ff        <= '0;
         loss_avg_ff        <= '0;
         gain_raw_ff        <= '0;
         lowest_ff          <= egl_pkg::LOWEST_RESET;
         highest_ff         <= '0;
         count_ff           <= '0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (s1_go) begin
            total_ff           <= total_in;
            prev_total_ff      <= prev_total_in;
            prev_total_vld_ff  <= prev_total_vld_in;
            prev_sample_ff     <= prev_sample_in;
            prev_sample_vld_ff <= prev_sample_vld_in;
            gain_avg_ff        <= gain_avg_in;
            loss_avg_ff        <= loss_avg_in;
            gain_raw_ff        <= gain_raw_in;
            lowest_ff          <= lowest_in;
            highest_ff         <= highest_in;
            count_ff           <= count_in;
         end
      end
   end

   // result item straight from the statistics registers
   assign rsp_chan.valid           = out_vld_ff;
   assign rsp_chan.avg_gain_tenths = gain_avg_ff;
   assign rsp_chan.avg_loss_tenths = loss_avg_ff;
   assign rsp_chan.raw_gain_m      = gain_raw_ff;
   assign rsp_chan.min_altitude    = lowest_ff;
   assign rsp_chan.max_altitude    = highest_ff;
   assign rsp_chan.sample_count    = count_ff;

endmodule

/* hdl/egl_checker.sv */
// port-level checks for the elevation tracker, bound to the top level
module egl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [egl_pkg::ACC_W-1:0]        rsp_avg_gain_tenths,
   input logic [egl_pkg::ACC_W-1:0]        rsp_avg_loss_tenths,
   input logic [egl_pkg::ACC_W-1:0]        rsp_raw_gain_m,
   input logic signed [egl_pkg::ALT_W-1:0] rsp_min_altitude,
   input logic [egl_pkg::MAX_W-1:0]        rsp_max_altitude,
   input logic [egl_pkg::ACC_W-1:0]        rsp_sample_count
);

   // nothing is offered right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

   // a stalled result stays valid and holds its count, average gain and minimum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_sample_count) &&
         $stable(rsp_avg_gain_tenths) && $stable(rsp_min_altitude))
      else $error("stalled result changed");

   // first sample of a route carries no climb, sets the minimum, and sets the maximum unless below zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_count == 32'd1 |->
         rsp_avg_gain_tenths == 32'd0 && rsp_avg_loss_tenths == 32'd0 &&
         rsp_raw_gain_m == 32'd0 &&
         ((!rsp_min_altitude[egl_pkg::ALT_W-1] &&
           rsp_max_altitude == rsp_min_altitude[egl_pkg::MAX_W-1:0]) ||
          (rsp_min_altitude[egl_pkg::ALT_W-1] && rsp_max_altitude == 15'd0)))
      else $error("first sample statistics wrong");

   // minimum never above maximum once a sample is in
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_count != 32'd0 |->
         $signed(rsp_min_altitude) <= $signed({1'b0, rsp_max_altitude}))
      else $error("minimum above maximum");

endmodule

bind elevation_gain_loss_tracker egl_checker u_egl_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_avg_gain_tenths (rsp_chan.avg_gain_tenths),
   .rsp_avg_loss_tenths (rsp_chan.avg_loss_tenths),
   .rsp_raw_gain_m      (rsp_chan.raw_gain_m),
   .rsp_min_altitude    (rsp_chan.min_altitude),
   .rsp_max_altitude    (rsp_chan.max_altitude),
   .rsp_sample_count    (rsp_chan.sample_count)
);

/* tb/tb_elevation_gain_loss_tracker.sv */
// self-checking testbench for the elevation gain and loss tracker
module tb_elevation_gain_loss_tracker;

   localparam int ALT_W        = egl_pkg::ALT_W;
   localparam int MAX_W        = egl_pkg::MAX_W;
   localparam int ACC_W        = egl_pkg::ACC_W;
   localparam int WIN          = 10;
   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_CYCLES  = 200;
   localparam int EXTREME_ITEMS = 40;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int MAX_REPORTS  = 30;
   localparam int TIMEOUT      = 5_000_000;
   localparam int DIR_N        = 25;

   // ways for the receiver to pace itself
   typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   // one statistics item as the block returns it
   typedef struct packed {
      logic [ACC_W-1:0]        avg_gain;
      logic [ACC_W-1:0]        avg_loss;
      logic [ACC_W-1:0]        raw_gain;
      logic signed [ALT_W-1:0] min_alt;
      logic [MAX_W-1:0]        max_alt;
      logic [ACC_W-1:0]        count;
   } egl_stats_type;

   // one row of the directed table; fixed marks a row whose result is typed in
   typedef struct packed {
      logic signed [ALT_W-1:0] alt;
      logic                    start;
      logic                    fixed;
      egl_stats_type           want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   egl_req_if sample_if ();
   egl_rsp_if stats_if ();

   elevation_gain_loss_tracker #(.WINDOW_LEN(WIN)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (sample_if),
      .rsp_chan (stats_if)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // --------------------------------------------------------------------------
   // predictor: a private copy of the route statistics
   // --------------------------------------------------------------------------
   logic signed [ALT_W-1:0] trk_ring [WIN];
   logic [3:0]              trk_ptr;
   logic [3:0]              trk_fill;
   logic signed [19:0]      trk_sum;
   logic signed [19:0]      trk_sum_prev;
   logic                    trk_sum_ok;
   logic signed [ALT_W-1:0] trk_last;
   logic                    trk_last_ok;
   logic [ACC_W-1:0]        trk_gain_avg;
   logic [ACC_W-1:0]        trk_loss_avg;
   logic [ACC_W-1:0]        trk_gain_raw;
   logic signed [ALT_W-1:0] trk_low;
   logic signed [ALT_W-1:0] trk_high;
   logic [ACC_W-1:0]        trk_count;

   egl_stats_type pending_stats [$];

   function automatic void clear_track();
      for (int j = 0; j < WIN; j++) trk_ring[j] = '0;
      trk_ptr      = '0;
      trk_fill     = '0;
      trk_sum      = '0;
      trk_sum_prev = '0;
      trk_sum_ok   = 1'b0;
      trk_last     = '0;
      trk_last_ok  = 1'b0;
      trk_gain_avg = '0;
      trk_loss_avg = '0;
      trk_gain_raw = '0;
      trk_low      = 16'sh7FFF;
      trk_high     = '0;
      trk_count    = '0;
   endfunction

   // climb sums and the count stick at all ones
   function automatic logic [ACC_W-1:0] climb_add(input logic [ACC_W-1:0] acc,
                                                  input logic [ACC_W-1:0] amount);
      logic [ACC_W:0] total;
      total = (ACC_W+1)'(acc) + (ACC_W+1)'(amount);
      return total[ACC_W] ? {ACC_W{1'b1}} : total[ACC_W-1:0];
   endfunction

   function automatic egl_stats_type advance_track(input logic signed [ALT_W-1:0] alt,
                                                   input logic start);
      int            delta;
      egl_stats_type res;
      if (start) clear_track();
      // running window sum: the oldest sample leaves once the ring is full
      if (trk_fill >= WIN) trk_sum = trk_sum - trk_ring[trk_ptr];
      else trk_fill = trk_fill + 4'd1;
      trk_sum = trk_sum + alt;
      trk_ring[trk_ptr] = alt;
      trk_ptr = (trk_ptr + 1 >= WIN) ? 4'd0 : trk_ptr + 4'd1;
      // the first full window only sets the reference sum
      if (trk_fill >= WIN) begin
         if (trk_sum_ok) begin
            delta = int'(trk_sum) - int'(trk_sum_prev);
            if (delta > 0) trk_gain_avg = climb_add(trk_gain_avg, delta);
            else if (delta < 0) trk_loss_avg = climb_add(trk_loss_avg, -delta);
         end
         trk_sum_prev = trk_sum;
         trk_sum_ok   = 1'b1;
      end
      // raw gain skips the first sample of a route
      if (trk_last_ok && alt > trk_last)
         trk_gain_raw = climb_add(trk_gain_raw, int'(alt) - int'(trk_last));
      trk_last    = alt;
      trk_last_ok = 1'b1;
      if (alt > trk_high) trk_high = alt;
      if (alt < trk_low) trk_low = alt;
      trk_count = climb_add(trk_count, 1);
      res.avg_gain = trk_gain_avg;
      res.avg_loss = trk_loss_avg;
      res.raw_gain = trk_gain_raw;
      res.min_alt  = trk_low;
      res.max_alt  = trk_high[MAX_W-1:0];
      res.count    = trk_count;
      return res;
   endfunction

   // --------------------------------------------------------------------------
   // sender: bursts of items with random gaps, prediction at acceptance
   // --------------------------------------------------------------------------
   int  faults;
   int  samples_sent;
   int  route_starts;
   int  results_checked;
   int  burst_left;
   bit  idle_on;
   bit  hold_req;
   rx_mode_type rx_mode;

   task automatic offer_item(input logic signed [ALT_W-1:0] alt, input logic start,
                             input logic fixed, input egl_stats_type want);
      egl_stats_type predicted;
      int            gap;
      sample_if.valid          <= 1'b1;
      sample_if.altitude       <= alt;
      sample_if.start_of_route <= start;
      @(posedge clock);
      while (!sample_if.ready) @(posedge clock);
      // accepted at this edge
      predicted = advance_track(alt, start);
      pending_stats.push_back(fixed ? want : predicted);
      samples_sent++;
      if (start) route_starts++;
      if (idle_on) begin
         if (burst_left == 0) begin
            // gap: valid drops and the payload wanders meanwhile
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
            burst_left = $urandom_range(0, 12);
            sample_if.valid          <= 1'b0;
            sample_if.altitude       <= ALT_W'($urandom);
            sample_if.start_of_route <= 1'(($urandom));
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // --------------------------------------------------------------------------
   // receiver: stall pattern of its own, plus a long hold-off on request
   // --------------------------------------------------------------------------
   initial begin : receiver
      int   hold_left;
      int   rx_phase;
      int   rx_period;
      int   rx_low;
      logic rdy;
      hold_left = 0;
      rx_phase  = 0;
      rx_period = 4;
      rx_low    = 1;
      stats_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (hold_req) begin
            // long hold-off so the pipeline fills and the input stalls
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rdy       = 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS: rdy = 1'b1;
               RX_RANDOM: rdy = ($urandom_range(0, 3) != 0);
               default: begin
                  // low for the first part of each period, period redrawn at wrap
                  rdy = (rx_phase >= rx_low);
                  rx_phase++;
                  if (rx_phase >= rx_period) begin
                     rx_phase  = 0;
                     rx_period = $urandom_range(2, 9);
                     rx_low    = $urandom_range(1, rx_period - 1);
                  end
               end
            endcase
         end
         stats_if.ready <= rdy;
      end
   end

   // --------------------------------------------------------------------------
   // checker: each accepted result against the oldest expectation
   // --------------------------------------------------------------------------
   task automatic check_field(input string name, input logic signed [ACC_W:0] want,
                              input logic signed [ACC_W:0] got);
      if (got !== want) begin
         faults++;
         if (faults <= MAX_REPORTS)
            $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      egl_stats_type want;
      if (!reset && stats_if.valid && stats_if.ready) begin
         if (pending_stats.size() == 0) begin
            faults++;
            if (faults <= MAX_REPORTS) $error("result item with no sample waiting");
         end else begin
            want = pending_stats.pop_front();
            results_checked++;
            check_field("avg_gain_tenths", want.avg_gain, stats_if.avg_gain_tenths);
            check_field("avg_loss_tenths", want.avg_loss, stats_if.avg_loss_tenths);
            check_field("raw_gain_m",      want.raw_gain, stats_if.raw_gain_m);
            check_field("min_altitude",    want.min_alt,  stats_if.min_altitude);
            check_field("max_altitude",    want.max_alt,  stats_if.max_altitude);
            check_field("sample_count",    want.count,    stats_if.sample_count);
         end
      end
   end

   // --------------------------------------------------------------------------
   // directed table: extremes, route starts, window fill and the first full window
   // --------------------------------------------------------------------------
   dir_row_type dir_rows [DIR_N];

   initial begin : stimulus
      int i;
      int k;
      int n;
      int route_len;
      int height;
      int n_random;

      faults          = 0;
      samples_sent    = 0;
      route_starts    = 0;
      results_checked = 0;
      burst_left      = 0;
      idle_on         = 1'b1;
      hold_req        = 1'b0;
      rx_mode         = RX_RANDOM;
      n_random        = 0;
      clear_track();

      sample_if.valid          <= 1'b0;
      sample_if.altitude       <= '0;
      sample_if.start_of_route <= 1'b0;
      reset                    <= 1'b1;

      dir_rows = '{
         // first sample after reset, no start flag
         '{0,      1'b0, 1'b1, '{0, 0, 0,     0,      0,     1}},
         // start flag with the lowest altitude: maximum stays at its floor
         '{-32768, 1'b1, 1'b1, '{0, 0, 0,     -32768, 0,     1}},
         // full-scale climb and a flat step
         '{32767,  1'b0, 1'b1, '{0, 0, 65535, -32768, 32767, 2}},
         '{32767,  1'b0, 1'b1, '{0, 0, 65535, -32768, 32767, 3}},
         '{-1,     1'b0, 1'b0, '0},
         '{100,    1'b0, 1'b0, '0},
         '{-500,   1'b0, 1'b0, '0},
         '{7,      1'b0, 1'b0, '0},
         '{32767,  1'b0, 1'b0, '0},
         // ninth sample of the route; the next row fills the window, reference sum only
         '{-32768, 1'b0, 1'b0, '0},
         '{250,    1'b0, 1'b0, '0},
         '{250,    1'b0, 1'b0, '0},
         '{0,      1'b0, 1'b0, '0},
         // fresh route at the highest altitude
         '{32767,  1'b1, 1'b1, '{0, 0, 0,     32767,  32767, 1}},
         // fresh route below zero, then a small climb
         '{-1,     1'b1, 1'b1, '{0, 0, 0,     -1,     0,     1}},
         '{5,      1'b0, 1'b1, '{0, 0, 6,     -1,     5,     2}},
         '{3,      1'b0, 1'b0, '0},
         '{9,      1'b0, 1'b0, '0},
         '{-4,     1'b0, 1'b0, '0},
         '{20,     1'b0, 1'b0, '0},
         '{20,     1'b0, 1'b0, '0},
         '{12,     1'b0, 1'b0, '0},
         '{-7,     1'b0, 1'b0, '0},
         '{1,      1'b0, 1'b0, '0},
         '{-30,    1'b0, 1'b0, '0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIR_N; i++)
         offer_item(dir_rows[i].alt, dir_rows[i].start, dir_rows[i].fixed, dir_rows[i].want);

      // back-pressure: receiver holds off while the sender keeps offering
      idle_on  = 1'b0;
      rx_mode  = RX_ALWAYS;
      hold_req = 1'b1;
      for (i = 0; i < 40; i++)
         offer_item(16'(int'($urandom_range(0, 2000)) - 1000), 1'b0, 1'b0, '0);

      // random part: mostly whole routes as random walks, some noise
      while (n_random < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         if ($urandom_range(0, 9) < 8) begin
            // short routes keep the window from filling now and then
            route_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12)
                                                    : $urandom_range(10, 60);
            height = int'($urandom_range(0, 65535)) - 32768;
            for (k = 0; k < route_len; k++) begin
               if (k > 0) begin
                  if ($urandom_range(0, 15) == 0)
                     height = int'($urandom_range(0, 65535)) - 32768;
                  else
                     height = height + int'($urandom_range(0, 400)) - 200;
                  if (height > 32767) height = 32767;
                  if (height < -32768) height = -32768;
               end
               offer_item(16'(height), (k == 0), 1'b0, '0);
               n_random++;
            end
         end else begin
            // noise: full-range samples with stray start flags
            n = $urandom_range(5, 30);
            for (k = 0; k < n; k++) begin
               offer_item(16'($urandom), ($urandom_range(0, 7) == 0), 1'b0, '0);
               n_random++;
            end
         end
      end

      // full rate at the extremes: ten high, ten low swings the window sum hard
      idle_on = 1'b0;
      rx_mode = RX_ALWAYS;
      for (i = 0; i < EXTREME_ITEMS; i++)
         offer_item(((i / WIN) % 2 == 0) ? 16'sh7FFF : 16'sh8000, (i == 0), 1'b0, '0);
      // then alternate low and high for the largest raw steps
      for (i = 0; i < EXTREME_ITEMS; i++)
         offer_item((i % 2 == 0) ? 16'sh8000 : 16'sh7FFF, 1'b0, 1'b0, '0);
      sample_if.valid <= 1'b0;

      // drain, then allow for the two-stage latency
      k = 0;
      while (pending_stats.size() != 0 && k < DRAIN_LIMIT) begin
         @(posedge clock);
         k++;
      end
      if (pending_stats.size() != 0) begin
         faults++;
         $error("%0d results never arrived", pending_stats.size());
      end
      repeat (8) @(posedge clock);

      $display("%0d samples over %0d route starts, %0d results checked", samples_sent,
               route_starts, results_checked);
      $display("directed extremes, long receiver hold-off, random routes and noise, %s",
               "full-rate swings between the altitude limits");
      if (faults == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(TIMEOUT);
      $display("run stopped by watchdog");
      $display("Test completed with failures");
      $finish;
   end

endmodule
